### hdl/triangle_tangent_frame_assert.svh
// Assertion macros for the triangle tangent frame block.
// Used by the port checker; needs signals clk and rst in the including scope.
`ifndef TRIANGLE_TANGENT_FRAME_ASSERT_SVH
`define TRIANGLE_TANGENT_FRAME_ASSERT_SVH

// Same-cycle implication, ignored while reset is high.
`define TTF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define TTF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also holds across reset.
`define TTF_ASSERT_NEXT_RAW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/ttf_pkg.sv
// Shared types and constants of the triangle tangent frame block.
// No dependencies; imported by every module of the block.
package ttf_pkg;

  localparam int INDEX_W              = 10;
  localparam int WORD_W               = 32;
  localparam int UNIT_W               = 16;
  localparam int DEFAULT_VERTEX_DEPTH = 1024;
  localparam int QUEUE_DEPTH          = 2;
  // 1.0 in Q2.14
  localparam int ONE_Q14              = 16384;

  localparam logic REQ_STORE    = 1'b0;
  localparam logic REQ_TRIANGLE = 1'b1;

  typedef struct packed {
    logic                      req_type;
    logic [INDEX_W-1:0]        vertex_index;
    logic signed [WORD_W-1:0]  pos_x;
    logic signed [WORD_W-1:0]  pos_y;
    logic signed [WORD_W-1:0]  pos_z;
    logic signed [WORD_W-1:0]  tex_s;
    logic signed [WORD_W-1:0]  tex_t;
    logic [INDEX_W-1:0]        corner_b_index;
    logic [INDEX_W-1:0]        corner_c_index;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0]  normal_x;
    logic signed [WORD_W-1:0]  normal_y;
    logic signed [WORD_W-1:0]  normal_z;
    logic signed [UNIT_W-1:0]  tangent_x;
    logic signed [UNIT_W-1:0]  tangent_y;
    logic signed [UNIT_W-1:0]  tangent_z;
    logic signed [UNIT_W-1:0]  bitangent_x;
    logic signed [UNIT_W-1:0]  bitangent_y;
    logic signed [UNIT_W-1:0]  bitangent_z;
    logic                      degenerate;
  } out_item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0]  pos_x;
    logic signed [WORD_W-1:0]  pos_y;
    logic signed [WORD_W-1:0]  pos_z;
    logic signed [WORD_W-1:0]  tex_s;
    logic signed [WORD_W-1:0]  tex_t;
  } corner_t;

  typedef struct packed {
    corner_t a;
    corner_t b;
    corner_t c;
  } tri_t;

endpackage

### hdl/triangle_tangent_frame.sv
// Triangle tangent frame: a store request writes one vertex entry, with no
// result, and store requests can follow each other every cycle while full is low.
// A triangle request holds full while its three corners are read from the
// single-port vertex store and until it enters the two-entry queue, where it
// waits for the compute engine. That engine uses its one shared 32x32 multiplier
// for normal, determinant and raw frame vectors; then, unless the determinant is
// zero, per vector it does a shift of one or four bits a cycle, three squares, a
// 32-step square root and three 15-step restoring divisions. A finished result
// waits in the output register while the next triangle runs.
// The vertex store has no reset; reading a corner never written gives
// undefined tangent, bitangent and normal fields.
module triangle_tangent_frame import ttf_pkg::*; #(
  parameter int VERTEX_DEPTH = DEFAULT_VERTEX_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  in_item_t  request,
  input  logic      pop,
  output logic      empty,
  output out_item_t result
);

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  tri_t q_wr;
  tri_t q_rd;

  ttf_front #(.VERTEX_DEPTH(VERTEX_DEPTH)) u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .request (request),
    .q_push  (q_push),
    .q_data  (q_wr),
    .q_full  (q_full)
  );

  ttf_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .full    (q_full),
    .wr_data (q_wr),
    .pop     (q_pop),
    .empty   (q_empty),
    .rd_data (q_rd)
  );

  ttf_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .q_data  (q_rd),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

endmodule

### hdl/ttf_front.sv
// Front end: vertex store, request decode and corner fetch.
// Depends on ttf_pkg; feeds fetched triangles to ttf_queue.
module ttf_front import ttf_pkg::*; #(
  parameter int VERTEX_DEPTH = DEFAULT_VERTEX_DEPTH
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  output logic     full,
  input  in_item_t request,
  output logic     q_push,
  output tri_t     q_data,
  input  logic     q_full
);

  localparam int AW = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;

  typedef enum logic [1:0] {F_IDLE, F_RB, F_RC, F_PUSH} fstate_t;

  fstate_t            state;
  corner_t            mem [VERTEX_DEPTH];
  corner_t            rd_q;
  corner_t            corner_a;
  corner_t            corner_b;
  logic [INDEX_W-1:0] idx_b;
  logic [INDEX_W-1:0] idx_c;
  logic               ok_a;
  logic               ok_b;
  logic               ok_c;
  logic [INDEX_W-1:0] rd_idx;
  logic               accept;

  function automatic logic in_range(input logic [INDEX_W-1:0] idx);
    in_range = ({{(32-INDEX_W){1'b0}}, idx} < 32'(VERTEX_DEPTH));
  endfunction

  function automatic logic [AW-1:0] to_addr(input logic [INDEX_W-1:0] idx);
    logic [AW+INDEX_W-1:0] e;
    e = (AW+INDEX_W)'(idx);
    to_addr = e[AW-1:0];
  endfunction

  assign full   = (state != F_IDLE);
  assign accept = push && !full;

  always_comb begin
    unique case (state)
      F_IDLE:  rd_idx = request.vertex_index;
      F_RB:    rd_idx = idx_b;
      F_RC:    rd_idx = idx_c;
      F_PUSH:  rd_idx = idx_c;
      default: rd_idx = idx_c;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept && request.req_type == REQ_STORE && in_range(request.vertex_index)) begin
      mem[to_addr(request.vertex_index)] <= '{pos_x: request.pos_x, pos_y: request.pos_y,
                                              pos_z: request.pos_z, tex_s: request.tex_s,
                                              tex_t: request.tex_t};
    end
  end

  always_ff @(posedge clk) begin
    rd_q <= mem[to_addr(rd_idx)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (accept && request.req_type == REQ_TRIANGLE) begin
            idx_b <= request.corner_b_index;
            idx_c <= request.corner_c_index;
            ok_a  <= in_range(request.vertex_index);
            ok_b  <= in_range(request.corner_b_index);
            ok_c  <= in_range(request.corner_c_index);
            state <= F_RB;
          end
        end
        F_RB: begin
          corner_a <= rd_q;
          state    <= F_RC;
        end
        F_RC: begin
          corner_b <= rd_q;
          state    <= F_PUSH;
        end
        F_PUSH: begin
          if (!q_full) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  // corners outside the store read as zero
  assign q_push   = (state == F_PUSH);
  assign q_data.a = ok_a ? corner_a : '0;
  assign q_data.b = ok_b ? corner_b : '0;
  assign q_data.c = ok_c ? rd_q : '0;

endmodule

### hdl/ttf_queue.sv
// Short queue of fetched triangles between front and back end.
// Depends on ttf_pkg for the entry type and depth.
module ttf_queue import ttf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  tri_t wr_data,
  input  logic pop,
  output logic empty,
  output tri_t rd_data
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  tri_t          slot [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;
  logic          do_push;
  logic          do_pop;

  function automatic logic [PW-1:0] advance(input logic [PW-1:0] p);
    advance = (p == PW'(QUEUE_DEPTH-1)) ? '0 : p + PW'(1);
  endfunction

  assign full    = (count == (PW+1)'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) slot[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= advance(wr_ptr);
      if (do_pop)  rd_ptr <= advance(rd_ptr);
      if (do_push && !do_pop) count <= count + (PW+1)'(1);
      else if (do_pop && !do_push) count <= count - (PW+1)'(1);
    end
  end

endmodule

### hdl/ttf_back.sv
// Back end: edges, normal, determinant, and tangent/bitangent normalisation.
// Depends on ttf_pkg; one shared multiplier, serial square root and divider.
module ttf_back import ttf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_empty,
  output logic      q_pop,
  input  tri_t      q_data,
  input  logic      pop,
  output logic      empty,
  output out_item_t result
);

  localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
  localparam logic [4:0]  N_PROD   = 5'd20;
  localparam logic [4:0]  N_SQ     = 5'd3;
  localparam logic [63:0] RT_START = 64'h4000_0000_0000_0000;
  localparam logic [3:0]  DIV_TOP  = 4'd14;

  typedef enum logic [3:0] {
    S_IDLE, S_EDGE, S_MUL, S_NSET, S_VLOAD, S_VSHIFT, S_VSQ,
    S_RTI, S_RT, S_DVI, S_DV, S_DVW, S_DONE
  } bstate_t;

  bstate_t                  state;
  logic signed [WORD_W-1:0] eu [3];
  logic signed [WORD_W-1:0] ev [3];
  logic signed [WORD_W-1:0] das, dat, dbs, dbt;
  logic [4:0]               mc;
  logic signed [63:0]       prod;
  logic                     pv;
  logic [4:0]               pidx;
  logic signed [63:0]       hold;
  logic signed [63:0]       res [10];
  logic signed [WORD_W-1:0] nrm [3];
  logic                     det_neg;
  logic                     degen;
  logic                     vsel;
  logic [63:0]              mag [3];
  logic                     vneg [3];
  logic [63:0]              len2;
  logic [63:0]              sq_n;
  logic [63:0]              sq_root;
  logic [63:0]              sq_bit;
  logic [45:0]              rem;
  logic [14:0]              qd;
  logic [1:0]               dk;
  logic [3:0]               di;
  logic signed [UNIT_W-1:0] tu [3];
  logic signed [UNIT_W-1:0] bu [3];
  logic                     ovalid;

  logic signed [WORD_W-1:0] a0, b0, a1, b1, ma, mb;
  logic signed [63:0]       mprod;
  logic                     issue;
  logic signed [63:0]       csel [3];
  logic [63:0]              ld_mag [3];
  logic [63:0]              mor;
  logic [63:0]              sq_op;
  logic [63:0]              dmag;
  logic [63:0]              rt_trial;
  logic [30:0]              len;
  logic [45:0]              dvs;
  logic signed [UNIT_W-1:0] qs;

  function automatic logic signed [WORD_W-1:0] sat_sub(input logic signed [WORD_W-1:0] x,
                                                        input logic signed [WORD_W-1:0] y);
    logic signed [WORD_W:0] d;
    d = {x[WORD_W-1], x} - {y[WORD_W-1], y};
    if (d[WORD_W] != d[WORD_W-1]) sat_sub = d[WORD_W] ? WORD_MIN : WORD_MAX;
    else sat_sub = d[WORD_W-1:0];
  endfunction

  // Q32.32 to Q16.16: add half, floor, saturate
  function automatic logic signed [WORD_W-1:0] round_q16(input logic signed [63:0] v);
    logic signed [64:0] w;
    logic signed [48:0] r;
    w = {v[63], v};
    w = w + 65'sd32768;
    r = w[64:16];
    if (r[48:31] == {18{r[31]}}) round_q16 = r[31:0];
    else round_q16 = r[48] ? WORD_MIN : WORD_MAX;
  endfunction

  always_comb begin
    unique case (mc[4:1])
      4'd0:    begin a0 = eu[1]; b0 = ev[2]; a1 = eu[2]; b1 = ev[1]; end
      4'd1:    begin a0 = eu[2]; b0 = ev[0]; a1 = eu[0]; b1 = ev[2]; end
      4'd2:    begin a0 = eu[0]; b0 = ev[1]; a1 = eu[1]; b1 = ev[0]; end
      4'd3:    begin a0 = das;   b0 = dbt;   a1 = dbs;   b1 = dat;   end
      4'd4:    begin a0 = dbt;   b0 = eu[0]; a1 = dat;   b1 = ev[0]; end
      4'd5:    begin a0 = dbt;   b0 = eu[1]; a1 = dat;   b1 = ev[1]; end
      4'd6:    begin a0 = dbt;   b0 = eu[2]; a1 = dat;   b1 = ev[2]; end
      4'd7:    begin a0 = das;   b0 = ev[0]; a1 = dbs;   b1 = eu[0]; end
      4'd8:    begin a0 = das;   b0 = ev[1]; a1 = dbs;   b1 = eu[1]; end
      4'd9:    begin a0 = das;   b0 = ev[2]; a1 = dbs;   b1 = eu[2]; end
      default: begin a0 = '0;    b0 = '0;    a1 = '0;    b1 = '0;    end
    endcase
    unique case (mc[1:0])
      2'd0:    sq_op = mag[0];
      2'd1:    sq_op = mag[1];
      default: sq_op = mag[2];
    endcase
    unique case (dk)
      2'd0:    dmag = mag[0];
      2'd1:    dmag = mag[1];
      default: dmag = mag[2];
    endcase
    if (state == S_VSQ) begin
      ma = sq_op[WORD_W-1:0];
      mb = sq_op[WORD_W-1:0];
    end else begin
      ma = mc[0] ? a1 : a0;
      mb = mc[0] ? b1 : b0;
    end
  end

  assign mprod = ma * mb;
  assign issue = ((state == S_MUL) && (mc < N_PROD)) || ((state == S_VSQ) && (mc < N_SQ));

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      csel[k]   = vsel ? res[7+k] : res[4+k];
      ld_mag[k] = csel[k][63] ? (~csel[k] + 64'd1) : csel[k];
    end
  end

  assign mor      = mag[0] | mag[1] | mag[2];
  assign rt_trial = sq_root + sq_bit;
  assign len      = sq_root[30:0];
  assign dvs      = 46'(len) << di;
  assign qs       = vneg[dk] ? -$signed({1'b0, qd}) : $signed({1'b0, qd});

  assign q_pop = (state == S_EDGE);
  assign empty = !ovalid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      pv     <= 1'b0;
      ovalid <= 1'b0;
    end else begin
      pv   <= issue;
      pidx <= mc;
      if (issue) prod <= mprod;
      if (pv) begin
        if (state == S_MUL) begin
          if (!pidx[0]) hold <= prod;
          else res[pidx[4:1]] <= hold - prod;
        end else begin
          len2 <= len2 + prod;
        end
      end
      if (pop && ovalid && state != S_DONE) ovalid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (!q_empty) state <= S_EDGE;
        end
        S_EDGE: begin
          eu[0] <= sat_sub(q_data.b.pos_x, q_data.a.pos_x);
          eu[1] <= sat_sub(q_data.b.pos_y, q_data.a.pos_y);
          eu[2] <= sat_sub(q_data.b.pos_z, q_data.a.pos_z);
          ev[0] <= sat_sub(q_data.c.pos_x, q_data.a.pos_x);
          ev[1] <= sat_sub(q_data.c.pos_y, q_data.a.pos_y);
          ev[2] <= sat_sub(q_data.c.pos_z, q_data.a.pos_z);
          das   <= sat_sub(q_data.b.tex_s, q_data.a.tex_s);
          dat   <= sat_sub(q_data.b.tex_t, q_data.a.tex_t);
          dbs   <= sat_sub(q_data.c.tex_s, q_data.a.tex_s);
          dbt   <= sat_sub(q_data.c.tex_t, q_data.a.tex_t);
          mc    <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          if (mc < N_PROD) mc <= mc + 5'd1;
          else state <= S_NSET;
        end
        S_NSET: begin
          for (int k = 0; k < 3; k++) nrm[k] <= round_q16(res[k]);
          det_neg <= res[3][63];
          vsel    <= 1'b0;
          degen   <= (res[3] == '0);
          state   <= (res[3] == '0) ? S_DONE : S_VLOAD;
        end
        S_VLOAD: begin
          // the sign of the determinant flips the whole vector
          for (int k = 0; k < 3; k++) begin
            mag[k]  <= ld_mag[k];
            vneg[k] <= csel[k][63] ^ det_neg;
          end
          state <= S_VSHIFT;
        end
        S_VSHIFT: begin
          // bring the largest magnitude into [2^29, 2^30)
          priority if (mor == '0) begin
            degen <= 1'b1;
            state <= S_DONE;
          end else if (|mor[63:33]) begin
            for (int k = 0; k < 3; k++) mag[k] <= mag[k] >> 4;
          end else if (|mor[63:30]) begin
            for (int k = 0; k < 3; k++) mag[k] <= mag[k] >> 1;
          end else if (~|mor[63:25]) begin
            for (int k = 0; k < 3; k++) mag[k] <= mag[k] << 4;
          end else if (!mor[29]) begin
            for (int k = 0; k < 3; k++) mag[k] <= mag[k] << 1;
          end else begin
            mc    <= '0;
            len2  <= '0;
            state <= S_VSQ;
          end
        end
        S_VSQ: begin
          if (mc < N_SQ) mc <= mc + 5'd1;
          else state <= S_RTI;
        end
        S_RTI: begin
          sq_n    <= len2;
          sq_root <= '0;
          sq_bit  <= RT_START;
          state   <= S_RT;
        end
        S_RT: begin
          if (sq_bit == '0) begin
            dk    <= '0;
            state <= S_DVI;
          end else begin
            if (sq_n >= rt_trial) begin
              sq_n    <= sq_n - rt_trial;
              sq_root <= (sq_root >> 1) + sq_bit;
            end else begin
              sq_root <= sq_root >> 1;
            end
            sq_bit <= sq_bit >> 2;
          end
        end
        S_DVI: begin
          rem   <= 46'({dmag[29:0], 14'd0}) + 46'(len >> 1);
          qd    <= '0;
          di    <= DIV_TOP;
          state <= S_DV;
        end
        S_DV: begin
          if (rem >= dvs) begin
            rem    <= rem - dvs;
            qd[di] <= 1'b1;
          end
          if (di == '0) state <= S_DVW;
          else di <= di - 4'd1;
        end
        S_DVW: begin
          if (vsel) bu[dk] <= qs;
          else tu[dk] <= qs;
          if (dk == 2'd2) begin
            if (vsel) begin
              state <= S_DONE;
            end else begin
              vsel  <= 1'b1;
              state <= S_VLOAD;
            end
          end else begin
            dk    <= dk + 2'd1;
            state <= S_DVI;
          end
        end
        S_DONE: begin
          if (!ovalid || pop) begin
            result.normal_x    <= nrm[0];
            result.normal_y    <= nrm[1];
            result.normal_z    <= nrm[2];
            result.tangent_x   <= degen ? '0 : tu[0];
            result.tangent_y   <= degen ? '0 : tu[1];
            result.tangent_z   <= degen ? '0 : tu[2];
            result.bitangent_x <= degen ? '0 : bu[0];
            result.bitangent_y <= degen ? '0 : bu[1];
            result.bitangent_z <= degen ? '0 : bu[2];
            result.degenerate  <= degen;
            ovalid             <= 1'b1;
            state              <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### hdl/triangle_tangent_frame_check.sv
// Port-level checker for triangle_tangent_frame, bound to the top level.
// Depends on ttf_pkg and triangle_tangent_frame_assert.svh.
`include "triangle_tangent_frame_assert.svh"

module triangle_tangent_frame_check import ttf_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      push,
  input logic      full,
  input in_item_t  request,
  input logic      pop,
  input logic      empty,
  input out_item_t result
);

  // come out of reset with nothing held and ready for an item
  `TTF_ASSERT_NEXT_RAW(a_reset_clear, rst, empty && !full, "not clear after reset")

  // only an accepted triangle stalls the input side
  `TTF_ASSERT_IMP(a_full_cause, $rose(full), $past(push) && $past(request.req_type == REQ_TRIANGLE), "full without a triangle")

  // a store never stalls the next item
  `TTF_ASSERT_NEXT(a_store_flow, push && !full && request.req_type == REQ_STORE, !full, "store stalled input")

  // a degenerate frame carries zero tangent and bitangent
  `TTF_ASSERT_IMP(a_degen_zero, !empty && result.degenerate, result.tangent_x == 0 && result.tangent_y == 0 && result.tangent_z == 0 && result.bitangent_x == 0 && result.bitangent_y == 0 && result.bitangent_z == 0, "degenerate frame not zeroed")

  // hold a waiting result until taken
  `TTF_ASSERT_NEXT(a_result_hold, !empty && !pop, !empty && $stable(result), "waiting result changed")

endmodule

bind triangle_tangent_frame triangle_tangent_frame_check u_check (.*);

### tb/triangle_tangent_frame_checker.sv
// Checker for the triangle tangent frame block: watches both queue ports,
// keeps its own copy of the vertex store and predicts each triangle frame.
// Depends on ttf_pkg for the item types.
module triangle_tangent_frame_checker import ttf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  logic      full,
  input  in_item_t  request,
  input  logic      pop,
  input  logic      empty,
  input  out_item_t result,
  output int        fail_count,
  output int        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  longint    pos_mem [DEFAULT_VERTEX_DEPTH][3];
  longint    tex_mem [DEFAULT_VERTEX_DEPTH][2];
  out_item_t frame_queue [$];

  function automatic longint sat_word(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Q32.32 to Q16.16: round half up, floor, saturate
  function automatic longint round_to_q16(longint v);
    longint w;
    w = v + 32768;
    return sat_word(w >>> 16);
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] root, bit_q;
    root = 0;
    bit_q = 64'd1 << 62;
    while (bit_q > n) bit_q >>= 2;
    while (bit_q != 0) begin
      if (n >= root + bit_q) begin
        n -= root + bit_q;
        root = (root >> 1) + bit_q;
      end else begin
        root >>= 1;
      end
      bit_q >>= 2;
    end
    return root;
  endfunction

  // Scale a raw vector to unit length in Q2.14; zero vector gives 0.
  function automatic bit to_unit(input longint c [3], output logic signed [15:0] o [3]);
    logic [63:0] mag [3];
    logic [63:0] m, len2, len, q;
    bit          neg [3];
    int          sh;
    m = 0;
    len2 = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = c[i] < 0;
      mag[i] = neg[i] ? 64'd0 - 64'(c[i]) : 64'(c[i]);
      if (mag[i] > m) m = mag[i];
      o[i] = '0;
    end
    if (m == 0) return 0;
    sh = 0;
    while ((m >> sh) >= (64'd1 << 30)) sh++;
    for (int i = 0; i < 3; i++) mag[i] >>= sh;
    m >>= sh;
    sh = 0;
    while ((m << sh) < (64'd1 << 29)) sh++;
    for (int i = 0; i < 3; i++) begin
      mag[i] <<= sh;
      len2 += mag[i] * mag[i];
    end
    len = int_sqrt(len2);
    for (int i = 0; i < 3; i++) begin
      q = (mag[i] * 16384 + len / 2) / len;
      o[i] = neg[i] ? -16'(q) : 16'(q);
    end
    return 1;
  endfunction

  function automatic out_item_t frame_of(in_item_t req);
    out_item_t            f;
    int                   idx [3];
    longint               p [3][3];
    longint               t [3][2];
    longint               eu [3], ev [3], nrm [3], tr [3], br [3];
    longint               da_s, da_t, db_s, db_t, det;
    logic signed [15:0]   tu [3], bu [3];
    bit                   ok;
    idx[0] = req.vertex_index;
    idx[1] = req.corner_b_index;
    idx[2] = req.corner_c_index;
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) p[i][k] = pos_mem[idx[i]][k];
      for (int k = 0; k < 2; k++) t[i][k] = tex_mem[idx[i]][k];
    end
    for (int k = 0; k < 3; k++) begin
      eu[k] = sat_word(p[1][k] - p[0][k]);
      ev[k] = sat_word(p[2][k] - p[0][k]);
    end
    nrm[0] = round_to_q16(eu[1] * ev[2] - eu[2] * ev[1]);
    nrm[1] = round_to_q16(eu[2] * ev[0] - eu[0] * ev[2]);
    nrm[2] = round_to_q16(eu[0] * ev[1] - eu[1] * ev[0]);
    da_s = sat_word(t[1][0] - t[0][0]);
    da_t = sat_word(t[1][1] - t[0][1]);
    db_s = sat_word(t[2][0] - t[0][0]);
    db_t = sat_word(t[2][1] - t[0][1]);
    det = da_s * db_t - db_s * da_t;
    for (int k = 0; k < 3; k++) begin
      tr[k] = db_t * eu[k] - da_t * ev[k];
      br[k] = da_s * ev[k] - db_s * eu[k];
      // only the sign of 1/det survives normalisation
      if (det < 0) begin
        tr[k] = -tr[k];
        br[k] = -br[k];
      end
    end
    ok = det != 0;
    if (ok) ok = to_unit(tr, tu);
    if (ok) ok = to_unit(br, bu);
    f.normal_x    = 32'(nrm[0]);
    f.normal_y    = 32'(nrm[1]);
    f.normal_z    = 32'(nrm[2]);
    f.tangent_x   = ok ? tu[0] : '0;
    f.tangent_y   = ok ? tu[1] : '0;
    f.tangent_z   = ok ? tu[2] : '0;
    f.bitangent_x = ok ? bu[0] : '0;
    f.bitangent_y = ok ? bu[1] : '0;
    f.bitangent_z = ok ? bu[2] : '0;
    f.degenerate  = !ok;
    return f;
  endfunction

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && push && !full) begin
      if (request.req_type == REQ_STORE) begin
        pos_mem[request.vertex_index][0] = $signed(request.pos_x);
        pos_mem[request.vertex_index][1] = $signed(request.pos_y);
        pos_mem[request.vertex_index][2] = $signed(request.pos_z);
        tex_mem[request.vertex_index][0] = $signed(request.tex_s);
        tex_mem[request.vertex_index][1] = $signed(request.tex_t);
      end else begin
        frame_queue = {frame_queue, frame_of(request)};
      end
    end
    if (!rst && pop && !empty) begin
      if (frame_queue.size() == 0) begin
        $error("result item with no triangle outstanding");
        fail_count++;
      end else begin
        want = frame_queue.pop_front();
        check_field("normal_x", $signed(want.normal_x), $signed(result.normal_x));
        check_field("normal_y", $signed(want.normal_y), $signed(result.normal_y));
        check_field("normal_z", $signed(want.normal_z), $signed(result.normal_z));
        check_field("tangent_x", $signed(want.tangent_x), $signed(result.tangent_x));
        check_field("tangent_y", $signed(want.tangent_y), $signed(result.tangent_y));
        check_field("tangent_z", $signed(want.tangent_z), $signed(result.tangent_z));
        check_field("bitangent_x", $signed(want.bitangent_x), $signed(result.bitangent_x));
        check_field("bitangent_y", $signed(want.bitangent_y), $signed(result.bitangent_y));
        check_field("bitangent_z", $signed(want.bitangent_z), $signed(result.bitangent_z));
        check_field("degenerate", want.degenerate, result.degenerate);
      end
    end
    pending = frame_queue.size();
  end

endmodule

### tb/testbench.sv
// Top of the triangle tangent frame testbench: clock, reset, stimulus and verdict.
// Depends on ttf_pkg, the block and triangle_tangent_frame_checker.
module testbench import ttf_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES  = 1500;
  localparam int HOLD_AT      = 700;
  localparam int STALL_LIMIT  = 20000;
  localparam int DRAIN_CYCLES = 400;
  localparam int RANDOM_ITEMS = 1400;

  logic      clk;
  logic      rst;
  logic      push;
  logic      full;
  in_item_t  request;
  logic      pop;
  logic      empty;
  out_item_t result;
  int        fail_count;
  int        pending;

  bit        written [DEFAULT_VERTEX_DEPTH];
  int        written_list [$];
  int        sent;
  bit        steady;
  int        quiet;

  triangle_tangent_frame dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .request(request),
    .pop(pop), .empty(empty), .result(result)
  );

  triangle_tangent_frame_checker checker_i (
    .clk(clk), .rst(rst), .push(push), .full(full), .request(request),
    .pop(pop), .empty(empty), .result(result),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'h7fffffff;
      2: return 32'h80000000;
      3: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      default: return 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
    endcase
  endfunction

  function automatic in_item_t noise_item();
    in_item_t it;
    it = $bits(in_item_t)'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    return it;
  endfunction

  // hand one item over; idle at random unless the steady stretch is on
  task automatic offer(in_item_t it);
    while (!steady && $urandom_range(0, 99) < 29) begin
      @(negedge clk);
      push <= 1'b0;
    end
    @(negedge clk);
    push <= 1'b1;
    request <= it;
    while (full) @(negedge clk);
    @(posedge clk);
    if (it.req_type == REQ_STORE && !written[it.vertex_index]) begin
      written[it.vertex_index] = 1;
      written_list = {written_list, int'(it.vertex_index)};
    end
    sent++;
  endtask

  task automatic store_vertex(int addr, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                              logic [31:0] s, logic [31:0] t);
    in_item_t it;
    it = noise_item();
    it.req_type = REQ_STORE;
    it.vertex_index = INDEX_W'(addr);
    it.pos_x = x;
    it.pos_y = y;
    it.pos_z = z;
    it.tex_s = s;
    it.tex_t = t;
    offer(it);
  endtask

  task automatic triangle(int a, int b, int c);
    in_item_t it;
    it = noise_item();
    it.req_type = REQ_TRIANGLE;
    it.vertex_index = INDEX_W'(a);
    it.corner_b_index = INDEX_W'(b);
    it.corner_c_index = INDEX_W'(c);
    offer(it);
  endtask

  function automatic int any_written();
    return written_list[$urandom_range(0, written_list.size() - 1)];
  endfunction

  // receiver: random pops, one long hold-off, steady stretch without idling
  initial begin
    bit held;
    held = 0;
    pop = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (!held && sent >= HOLD_AT) begin
        held = 1;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      pop <= steady || $urandom_range(0, 99) >= 29;
    end
  end

  // watchdog: cycles with no item accepted on either side
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    int a, b, c;
    rst = 1'b1;
    push = 1'b0;
    request = '0;
    sent = 0;
    steady = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // extremes, saturating edges and normals, both det signs, degenerate cases
    store_vertex(0, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h0, 32'h0);
    store_vertex(1023, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h0);
    store_vertex(1, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h0, 32'h80000000);
    store_vertex(2, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    store_vertex(3, 32'h00010000, 32'h0, 32'h0, 32'h00010000, 32'h0);
    store_vertex(4, 32'h0, 32'h00010000, 32'h0, 32'h0, 32'h00010000);
    store_vertex(5, 32'h0, 32'h0, 32'h0, 32'h00030000, 32'h00020000);
    store_vertex(6, 32'h00020000, 32'h00020000, 32'h0, 32'h00020000, 32'h00020000);
    triangle(0, 1023, 1);
    triangle(1023, 0, 1);
    triangle(2, 3, 4);
    triangle(2, 4, 3);
    triangle(3, 3, 3);
    triangle(2, 5, 3);
    triangle(2, 3, 6);
    triangle(0, 1, 1023);
    triangle(1, 2, 0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady = n >= 300 && n < 450;
      if ($urandom_range(0, 99) < 40) begin
        store_vertex($urandom_range(0, DEFAULT_VERTEX_DEPTH - 1), rand_word(), rand_word(),
                     rand_word(), rand_word(), rand_word());
      end else begin
        a = any_written();
        b = any_written();
        c = any_written();
        // now and then share a corner to hit zero edges
        if ($urandom_range(0, 9) == 0) b = a;
        triangle(a, b, c);
      end
    end
    @(negedge clk);
    push <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
